// ===== hw/rtl/pee_pkg.sv =====
// ============================================================================
// pee_pkg
// Shared constants and types for the postfix expression evaluator.
// ============================================================================
package pee_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int STEP_W      = $clog2(WORD_W);
  localparam int SYM_W       = 8;
  localparam int CFG_W       = 7;
  localparam int STAT_W      = 2;
  localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(64);

  // Expression characters
  localparam logic [SYM_W-1:0] CH_ZERO = 8'd48;
  localparam logic [SYM_W-1:0] CH_MUL  = 8'd42;
  localparam logic [SYM_W-1:0] CH_ADD  = 8'd43;
  localparam logic [SYM_W-1:0] CH_SUB  = 8'd45;
  localparam logic [SYM_W-1:0] CH_DIV  = 8'd47;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd3;

  localparam logic [WORD_W-1:0] NEG_ONE = '1;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_POP_R,
    DP_CAP_R,
    DP_POP_L,
    DP_CAP_L,
    DP_EXEC,
    DP_DIV_WAIT,
    DP_PUSH,
    DP_RD_TOP,
    DP_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic is_op;
    logic is_div;
    logic right_zero;
    logic last;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pee_in_if.sv =====
// ============================================================================
// pee_in_if
// Input channel: one expression character per item.
// ============================================================================
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== hw/rtl/pee_out_if.sv =====
// ============================================================================
// pee_out_if
// Output channel: expression value and status per item.
// ============================================================================
interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/pee_ram.sv =====
// ============================================================================
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pee_div.sv =====
// ============================================================================
// pee_div
// Iterative signed 32-bit divider, truncating, one quotient bit per cycle.
// ============================================================================
module pee_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pee_pkg::WORD_W-1:0] dividend,
  input  logic [pee_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [pee_pkg::WORD_W-1:0] quotient
);
  import pee_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_t;

  div_state_t        state;
  logic [STEP_W-1:0] step;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic              neg;

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] trial;

  assign shifted = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            dvs   <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            neg   <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rem   <= '0;
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (trial[WORD_W]) begin
            rem <= shifted;
            quo <= {quo[WORD_W-2:0], 1'b0};
          end else begin
            rem <= trial;
            quo <= {quo[WORD_W-2:0], 1'b1};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(WORD_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quotient <= neg ? (WORD_W'(0) - quo) : quo;
          done     <= 1'b1;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pee_ctrl.sv =====
// ============================================================================
// pee_ctrl
// Sequencer: steps the datapath through pop, execute, push and result.
// ============================================================================
module pee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pee_pkg::dp_stat_t stat,
  output pee_pkg::dp_op_t   op
);
  import pee_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_R, S_CAP_R, S_POP_L, S_CAP_L,
    S_EXEC, S_DIV, S_PUSH, S_TOP, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:   op = in_valid ? DP_LOAD : DP_NOP;
      S_DECODE: op = DP_NOP;
      S_POP_R:  op = DP_POP_R;
      S_CAP_R:  op = DP_CAP_R;
      S_POP_L:  op = DP_POP_L;
      S_CAP_L:  op = DP_CAP_L;
      S_EXEC:   op = DP_EXEC;
      S_DIV:    op = DP_DIV_WAIT;
      S_PUSH:   op = DP_PUSH;
      S_TOP:    op = DP_RD_TOP;
      S_OUT:    op = stat.out_free ? DP_OUT : DP_NOP;
      default:  op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_DECODE;
        S_DECODE: state <= stat.is_op ? S_POP_R : S_PUSH;
        S_POP_R:  state <= S_CAP_R;
        S_CAP_R:  state <= S_POP_L;
        S_POP_L:  state <= S_CAP_L;
        S_CAP_L:  state <= S_EXEC;
        S_EXEC:   state <= (stat.is_div && !stat.right_zero) ? S_DIV : S_PUSH;
        S_DIV:    if (stat.div_done) state <= S_PUSH;
        S_PUSH:   state <= stat.last ? S_TOP : S_IDLE;
        S_TOP:    state <= S_OUT;
        S_OUT:    if (stat.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pee_datapath.sv =====
// ============================================================================
// pee_datapath
// Operand stack, operand registers, ALU, divider and result register.
// ============================================================================
module pee_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pee_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [pee_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  input  pee_pkg::dp_op_t           op,
  output pee_pkg::dp_stat_t         stat,
  pee_out_if.source                 result
);
  import pee_pkg::*;

  logic [CFG_W-1:0]  stack_limit;
  logic [SYM_W-1:0]  sym;
  logic              last_q;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] err;
  logic              pop_hit;
  logic [WORD_W-1:0] right;
  logic [WORD_W-1:0] left;
  logic [WORD_W-1:0] res;
  logic              out_valid;
  logic [WORD_W-1:0] out_value;
  logic [STAT_W-1:0] out_status;

  logic [CNT_W-1:0]  count_dec;
  logic [LIM_W-1:0]  lim;
  logic              full;
  logic              is_op;
  logic              is_div;
  logic [WORD_W-1:0] push_val;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  function automatic logic [STAT_W-1:0] note(input logic [STAT_W-1:0] cur,
                                             input logic [STAT_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign count_dec = count - CNT_W'(1);
  assign is_div    = (sym == CH_DIV);
  assign is_op     = (sym == CH_ADD) || (sym == CH_SUB) || (sym == CH_MUL) || is_div;

  // Limit clamped to 1 .. STACK_DEPTH
  always_comb begin
    if (stack_limit == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(stack_limit) > LIM_W'(STACK_DEPTH)) begin
      lim = LIM_W'(STACK_DEPTH);
    end else begin
      lim = LIM_W'(stack_limit);
    end
  end

  assign full     = (LIM_W'(count) >= lim);
  assign push_val = is_op ? res : (WORD_W'(sym) - WORD_W'(CH_ZERO));

  assign ram_we    = (op == DP_PUSH) && !full;
  assign ram_re    = ((op == DP_POP_R) || (op == DP_POP_L) || (op == DP_RD_TOP))
                     && (count != '0);
  assign ram_raddr = count_dec[ADDR_W-1:0];
  assign div_start = (op == DP_EXEC) && is_div && (right != '0);

  pee_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(push_val),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pee_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(left),
    .divisor (right),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      stack_limit <= cfg_wdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // a new result wins over the one being taken
      if (op == DP_OUT) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        DP_POP_R, DP_POP_L: begin
          if (count == '0) begin
            err <= note(err, ST_UNDER);
          end else begin
            count <= count_dec;
          end
        end
        DP_EXEC: begin
          if (is_div && (right == '0)) begin
            err <= note(err, ST_DIVZ);
          end
        end
        DP_PUSH: begin
          if (full) begin
            err <= note(err, ST_OVER);
          end else begin
            count <= count + CNT_W'(1);
          end
        end
        DP_OUT: begin
          count <= '0;
          err   <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        sym    <= symbol;
        last_q <= last;
      end
      DP_POP_R: begin
        pop_hit <= (count != '0);
        right   <= NEG_ONE;
      end
      DP_CAP_R: if (pop_hit) right <= ram_rdata;
      DP_POP_L: begin
        pop_hit <= (count != '0);
        left    <= NEG_ONE;
      end
      DP_CAP_L: if (pop_hit) left <= ram_rdata;
      DP_EXEC: begin
        unique case (sym)
          CH_ADD:  res <= left + right;
          CH_SUB:  res <= left - right;
          CH_MUL:  res <= left * right;
          default: res <= '0;
        endcase
      end
      DP_DIV_WAIT: if (div_done) res <= div_q;
      DP_RD_TOP:   pop_hit <= (count != '0);
      DP_OUT: begin
        out_value  <= pop_hit ? ram_rdata : '0;
        out_status <= pop_hit ? err : note(err, ST_UNDER);
      end
      default: ;
    endcase
  end

  assign stat.is_op      = is_op;
  assign stat.is_div     = is_div;
  assign stat.right_zero = (right == '0);
  assign stat.last       = last_q;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid || result.ready;

  assign result.valid  = out_valid;
  assign result.value  = $signed(out_value);
  assign result.status = out_status;

endmodule

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// ============================================================================
// postfix_expression_evaluator_unit
// Reverse Polish evaluator over a bounded 32-bit operand stack.
// ============================================================================
//
//  channel  | dir | payload                    | notes
//  ---------+-----+----------------------------+------------------------------
//  expr     | in  | symbol[7:0], last          | one character per item
//  result   | out | value[31:0] signed, status | one item per marked-last char
//  cfg      | in  | cfg_wdata[6:0]             | stack_limit, write on cfg_we
//
//  Operands push directly; operators pop right, then left, execute and push,
//  / also waiting on the iterative divider (one quotient bit per cycle); a
//  last char adds a stack-top read. The RAM's single read port sets the pops.
//  rst is synchronous: stack empty, status ok, stack_limit back to 64.
//  The result register frees the input side: a new item is taken while a
//  result waits; only a second last character stalls until it is taken.
//
module postfix_expression_evaluator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pee_pkg::CFG_W-1:0] cfg_wdata,
  pee_in_if.sink                    expr,
  pee_out_if.source                 result
);
  import pee_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;
  logic     in_ready;

  assign expr.ready = in_ready;

  // Sequencer
  pee_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(expr.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .op      (op)
  );

  // Stack, ALU, divider and result register
  pee_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .symbol   (expr.symbol),
    .last     (expr.last),
    .op       (op),
    .stat     (stat),
    .result   (result)
  );

endmodule
